### src/ctq_pkg.sv
`timescale 1ns / 1ps
package ctq_pkg;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_CHK = 2'd2;
  localparam logic [1:0] ACT_CLR = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EXPIRED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [15:0] WAIT_RESET = 16'd20;
  localparam logic [31:0] MAX_TIME   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  conn_id;
    logic [31:0] sequence_req;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  conn_id_out;
    logic [31:0] sequence_out;
    logic [6:0]  entry_count;
    logic [31:0] earliest_deadline;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] dl;
    logic [9:0]  conn;
    logic [31:0] seq;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MID  = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

### src/connection_timeout_timer_queue_unit.sv
`timescale 1ns / 1ps
// Deadline-sorted timer table. The table lives in two banks of synchronous RAM; add, delete
// and check copy the live bank into the other one entry per cycle, then swap banks, so the
// single read port of the live bank sets the pace. An add runs the scan, the insert and any
// tail copy (no scan on an empty table), a delete runs the scan alone, and a check that fires
// runs the scan, the rearm of its expired entries and any tail copy; each then gives its final
// result as the banks swap. Clear, a full-table add, a delete on an empty table and a check with
// nothing expired answer on the next cycle.
// Results appear on out_valid for one cycle each and cannot be held off; an expired
// check emits one result per expired entry, the final one with last set. busy stays high
// until the last result is issued.
module connection_timeout_timer_queue_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ctq_pkg::in_item_t in_item,
  output logic              busy,
  output logic              out_valid,
  output ctq_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import ctq_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = $bits(entry_t);

  state_t          state_r, state_nxt;
  logic [1:0]      act_r, act_nxt;
  logic [9:0]      conn_r, conn_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [31:0]     dlr_r, dlr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]     head_r, head_nxt;
  logic            bank_r, bank_nxt;
  logic [CW-1:0]   rd_r, rd_nxt;
  logic            rv_r, rv_nxt;
  logic [CW-1:0]   rvi_r, rvi_nxt;
  logic [CW-1:0]   wr_r, wr_nxt;
  logic [CW-1:0]   exp_r, exp_nxt;
  logic [CW-1:0]   stop_r, stop_nxt;
  entry_t          hold_r, hold_nxt;
  logic            ov_r, ov_nxt;
  out_item_t       out_r, out_nxt;
  logic [15:0]     wait_r;

  logic            issue;
  logic            we;
  entry_t          wdata;
  entry_t          rdata;
  logic [EW-1:0]   rdata0, rdata1;
  logic [32:0]     dl_sum;
  logic [31:0]     dl_new;

  assign dl_sum = {1'b0, in_item.now} + {17'b0, wait_r};
  assign dl_new = dl_sum[32] ? MAX_TIME : dl_sum[31:0];

  assign rdata = bank_r ? entry_t'(rdata1) : entry_t'(rdata0);

  assign issue = ((state_r == S_SCAN || state_r == S_TAIL) && rd_r < cnt_r) ||
                 (state_r == S_MID && act_r == ACT_CHK && rd_r < exp_r);

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    conn_nxt  = conn_r;
    seq_nxt   = seq_r;
    now_nxt   = now_r;
    dlr_nxt   = dlr_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    exp_nxt   = exp_r;
    stop_nxt  = stop_r;
    hold_nxt  = hold_r;
    rv_nxt    = issue;
    rd_nxt    = issue ? rd_r + CW'(1) : rd_r;
    rvi_nxt   = rd_r;
    we        = 1'b0;
    wdata     = rdata;
    ov_nxt    = 1'b0;
    out_nxt   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt  = in_item.action;
          conn_nxt = in_item.conn_id;
          seq_nxt  = in_item.sequence_req;
          now_nxt  = in_item.now;
          dlr_nxt  = dl_new;
          exp_nxt  = '0;
          rd_nxt   = '0;
          rv_nxt   = 1'b0;
          out_nxt.entry_count       = 7'(cnt_r);
          out_nxt.earliest_deadline = (cnt_r == '0) ? '0 : head_r;
          out_nxt.last              = 1'b1;
          case (in_item.action)
            ACT_ADD: begin
              if (cnt_r == CW'(TABLE_ENTRIES)) begin
                ov_nxt         = 1'b1;
                out_nxt.status = ST_FULL;
              end else if (cnt_r == '0) begin
                stop_nxt  = '0;
                state_nxt = S_MID;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_DEL: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_CHK: begin
              if (cnt_r != '0 && head_r < in_item.now) begin
                state_nxt = S_SCAN;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            default: begin
              cnt_nxt                   = '0;
              ov_nxt                    = 1'b1;
              out_nxt.entry_count       = '0;
              out_nxt.earliest_deadline = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rv_r) begin
          if (act_r == ACT_DEL) begin
            we = (rdata.conn != conn_r);
            if (rvi_r == cnt_r - CW'(1)) begin
              state_nxt = S_DONE;
              rv_nxt    = 1'b0;
            end
          end else if (act_r == ACT_CHK && rdata.dl <= now_r) begin
            exp_nxt = exp_r + CW'(1);
            if (rvi_r == cnt_r - CW'(1)) begin
              stop_nxt  = cnt_r;
              state_nxt = S_MID;
              rd_nxt    = '0;
              rv_nxt    = 1'b0;
            end
          end else if (rdata.dl <= dlr_r) begin
            we = 1'b1;
            if (rvi_r == cnt_r - CW'(1)) begin
              stop_nxt  = cnt_r;
              state_nxt = S_MID;
              rd_nxt    = '0;
              rv_nxt    = 1'b0;
            end
          end else begin
            stop_nxt  = rvi_r;
            state_nxt = S_MID;
            rd_nxt    = '0;
            rv_nxt    = 1'b0;
          end
        end
      end
      S_MID: begin
        if (act_r == ACT_ADD) begin
          we        = 1'b1;
          wdata     = '{dl: dlr_r, conn: conn_r, seq: seq_r};
          state_nxt = (stop_r == cnt_r) ? S_DONE : S_TAIL;
          rd_nxt    = stop_r;
          rv_nxt    = 1'b0;
        end else if (rv_r) begin
          we       = 1'b1;
          wdata    = '{dl: dlr_r, conn: rdata.conn, seq: rdata.seq};
          hold_nxt = rdata;
          if (rvi_r != '0) begin
            ov_nxt                    = 1'b1;
            out_nxt.status            = ST_EXPIRED;
            out_nxt.conn_id_out       = hold_r.conn;
            out_nxt.sequence_out      = hold_r.seq;
            out_nxt.entry_count       = 7'(cnt_r);
            out_nxt.earliest_deadline = rdata.dl;
          end
          if (rvi_r == exp_r - CW'(1)) begin
            state_nxt = (stop_r == cnt_r) ? S_DONE : S_TAIL;
            rd_nxt    = stop_r;
            rv_nxt    = 1'b0;
          end
        end
      end
      S_TAIL: begin
        if (rv_r) begin
          we = 1'b1;
          if (rvi_r == cnt_r - CW'(1)) begin
            state_nxt = S_DONE;
            rv_nxt    = 1'b0;
          end
        end
      end
      S_DONE: begin
        cnt_nxt                   = wr_r;
        bank_nxt                  = ~bank_r;
        state_nxt                 = S_IDLE;
        ov_nxt                    = 1'b1;
        out_nxt.entry_count       = 7'(wr_r);
        out_nxt.earliest_deadline = (wr_r == '0) ? '0 : head_r;
        out_nxt.last              = 1'b1;
        if (act_r == ACT_CHK) begin
          out_nxt.status       = ST_EXPIRED;
          out_nxt.conn_id_out  = hold_r.conn;
          out_nxt.sequence_out = hold_r.seq;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    wr_nxt   = (state_r == S_IDLE) ? '0 : (we ? wr_r + CW'(1) : wr_r);
    head_nxt = (we && wr_r == '0) ? wdata.dl : head_r;
  end

  ctq_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_bank0 (
    .clk  (clk),
    .we   (we && bank_r),
    .waddr(wr_r[AW-1:0]),
    .wdata(wdata),
    .raddr(rd_r[AW-1:0]),
    .rdata(rdata0)
  );

  ctq_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_bank1 (
    .clk  (clk),
    .we   (we && !bank_r),
    .waddr(wr_r[AW-1:0]),
    .wdata(wdata),
    .raddr(rd_r[AW-1:0]),
    .rdata(rdata1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
      rv_r    <= 1'b0;
      rd_r    <= '0;
      wr_r    <= '0;
      exp_r   <= '0;
      stop_r  <= '0;
      ov_r    <= 1'b0;
      wait_r  <= WAIT_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bank_r  <= bank_nxt;
      rv_r    <= rv_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      exp_r   <= exp_nxt;
      stop_r  <= stop_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        wait_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    conn_r <= conn_nxt;
    seq_r  <= seq_nxt;
    now_r  <= now_nxt;
    dlr_r  <= dlr_nxt;
    head_r <= head_nxt;
    rvi_r  <= rvi_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

### src/ctq_ram.sv
`timescale 1ns / 1ps
module ctq_ram #(
  parameter int WIDTH = 74,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ctq_checker.sv
`timescale 1ns / 1ps
module ctq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input ctq_pkg::out_item_t out_item
);
  import ctq_pkg::*;

  // only expired items can be followed by more results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_EXPIRED |-> out_item.last)
    else $error("non-expiry result without last");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || (out_valid && out_item.last))
    else $error("accepted item neither worked on nor answered");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("still busy after final result");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("intermediate result while idle");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.entry_count == 7'd0 |-> out_item.earliest_deadline == 32'd0)
    else $error("empty table reports a deadline");

endmodule

bind connection_timeout_timer_queue_unit ctq_checker u_ctq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ctq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  connection_timeout_timer_queue_unit #(.TABLE_ENTRIES(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // timer table shadow
  entry_t tbl[$];
  logic [15:0] wait_sec = WAIT_RESET;
  out_item_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic logic [31:0] deadline_of(logic [31:0] now);
    logic [32:0] d;
    d = {1'b0, now} + {17'd0, wait_sec};
    return d[32] ? MAX_TIME : d[31:0];
  endfunction

  function automatic void insert_sorted(entry_t e);
    int p;
    p = 0;
    while (p < tbl.size() && tbl[p].dl <= e.dl) p++;
    tbl.insert(p, e);
  endfunction

  function automatic void push_result(logic [1:0] st, logic [9:0] c, logic [31:0] s, bit lst);
    out_item_t r;
    r.status = st;
    r.conn_id_out = c;
    r.sequence_out = s;
    r.entry_count = 7'(tbl.size());
    r.earliest_deadline = tbl.size() > 0 ? tbl[0].dl : 32'd0;
    r.last = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_timer(in_item_t it);
    entry_t e;
    int n;
    int i;
    logic [31:0] rearm;
    case (it.action)
      ACT_ADD: begin
        if (tbl.size() >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1);
        end else begin
          e.dl = deadline_of(it.now);
          e.conn = it.conn_id;
          e.seq = it.sequence_req;
          insert_sorted(e);
          push_result(ST_DONE, '0, '0, 1);
        end
      end
      ACT_DEL: begin
        i = 0;
        while (i < tbl.size()) begin
          if (tbl[i].conn == it.conn_id) tbl.delete(i);
          else i++;
        end
        push_result(ST_DONE, '0, '0, 1);
      end
      ACT_CLR: begin
        tbl.delete();
        push_result(ST_DONE, '0, '0, 1);
      end
      default: begin
        if (tbl.size() == 0 || !(tbl[0].dl < it.now)) begin
          push_result(ST_DONE, '0, '0, 1);
        end else begin
          n = 0;
          rearm = deadline_of(it.now);
          while (n < tbl.size() && tbl[n].dl <= it.now) n++;
          for (int k = 0; k < n; k++) begin
            e = tbl[0];
            tbl.delete(0);
            e.dl = rearm;
            insert_sorted(e);
            push_result(ST_EXPIRED, e.conn, e.seq, k + 1 == n);
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t x;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_item);
        errors++;
      end else begin
        x = pending_results[0];
        pending_results.delete(0);
        if (out_item.status !== x.status) begin
          $error("status exp %0d got %0d", x.status, out_item.status); errors++;
        end
        if (out_item.conn_id_out !== x.conn_id_out) begin
          $error("conn_id_out exp %0d got %0d", x.conn_id_out, out_item.conn_id_out); errors++;
        end
        if (out_item.sequence_out !== x.sequence_out) begin
          $error("sequence_out exp %0h got %0h", x.sequence_out, out_item.sequence_out);
          errors++;
        end
        if (out_item.entry_count !== x.entry_count) begin
          $error("entry_count exp %0d got %0d", x.entry_count, out_item.entry_count); errors++;
        end
        if (out_item.earliest_deadline !== x.earliest_deadline) begin
          $error("earliest_deadline exp %0h got %0h", x.earliest_deadline,
                 out_item.earliest_deadline);
          errors++;
        end
        if (out_item.last !== x.last) begin
          $error("last exp %0d got %0d", x.last, out_item.last); errors++;
        end
      end
    end
  end

  task automatic idle_inputs();
    start <= 1'b0;
    in_item <= in_item_t'({$urandom, $urandom, 12'($urandom)});
  endtask

  task automatic send_item(logic [1:0] act, logic [9:0] c, logic [31:0] s, logic [31:0] t);
    in_item_t it;
    it.action = act;
    it.conn_id = c;
    it.sequence_req = s;
    it.now = t;
    while ($urandom_range(99) < idle_pct) begin
      idle_inputs();
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer(it);
  endtask

  task automatic drain();
    idle_inputs();
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic set_wait(logic [15:0] w);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    wait_sec = w;
  endtask

  task automatic test_directed();
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd100);
    send_item(ACT_ADD, 10'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 10'd1023, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_ADD, 10'd5, 32'h1234_5678, 32'hFFFF_FFF0);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd20);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd21);
    send_item(ACT_DEL, 10'd1023, 32'd0, 32'd0);
    send_item(ACT_DEL, 10'd77, 32'd0, 32'd0);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_CLR, 10'd0, 32'd0, 32'd0);
    for (int i = 0; i < DEPTH + 1; i++) send_item(ACT_ADD, 10'(i % 4), $urandom, 32'd10);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd40);
    send_item(ACT_DEL, 10'd2, 32'd0, 32'd0);
    send_item(ACT_CLR, 10'd0, 32'd0, 32'd0);
  endtask

  task automatic test_wait_extremes();
    set_wait(16'd0);
    send_item(ACT_ADD, 10'd3, 32'd9, 32'd50);
    send_item(ACT_ADD, 10'd4, 32'd8, 32'd50);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd51);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'd51);
    set_wait(16'hFFFF);
    send_item(ACT_ADD, 10'd6, 32'd1, 32'hFFFF_0000);
    send_item(ACT_CHK, 10'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_CLR, 10'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random(int count, int pct);
    logic [31:0] clock_now;
    int r;
    idle_pct = pct;
    clock_now = $urandom_range(1000);
    if ($urandom_range(3) == 0) clock_now = 32'hFFFF_FF00 + $urandom_range(200);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      clock_now = clock_now + $urandom_range(wait_sec / 4 + 2);
      if (r < 50) send_item(ACT_ADD, 10'($urandom_range(15)) | ($urandom_range(9) == 0 ?
                              10'($urandom) : 10'd0), $urandom, clock_now);
      else if (r < 80) send_item(ACT_CHK, 10'($urandom), $urandom, clock_now);
      else if (r < 93) send_item(ACT_DEL, 10'($urandom_range(15)), $urandom, clock_now);
      else if (r < 97) send_item(ACT_CLR, 10'($urandom), $urandom, clock_now);
      else send_item(2'($urandom), 10'($urandom), $urandom, $urandom);
    end
    idle_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wait_extremes();
    set_wait(16'd30);
    test_random(70, 0);
    drain();
    set_wait(16'd7);
    test_random(70, 80);
    set_wait(16'd1);
    test_random(70, 38);
    set_wait(16'd100);
    test_random(70, 0);
    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
